// File: design/alr_pkg.sv
// Shared types, constants and colour weighting for the antialiased line rasterizer.
// Used by every module of the design; depends on nothing else.

package alr_pkg;

    // Fixed field widths
    localparam int COORD_BITS    = 14;
    localparam int FRAC_BITS     = 8;
    localparam int OUT_BITS      = COORD_BITS + 1;
    localparam int ACC_BITS      = COORD_BITS + FRAC_BITS + 2;
    localparam int SLOPE_BITS    = FRAC_BITS + 2;
    localparam int DIM_BITS      = 13;
    localparam int COLOUR_BITS   = 32;
    localparam int CHAN_BITS     = 8;
    localparam int IN_DATA_BITS  = 88;
    localparam int OUT_DATA_BITS = 128;

    // Command codes carried in tuser
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;

    // Full weight: all fraction bits set
    localparam logic [FRAC_BITS-1:0] WEIGHT_FULL = '1;

    // One queue entry: either a prepared line or an advance command.
    typedef struct packed {
        logic                          kind;
        logic                          steep;
        logic                          axis_only;
        logic signed [COORD_BITS-1:0]  major_pos;
        logic signed [COORD_BITS-1:0]  major_end;
        logic signed [COORD_BITS-1:0]  minor_start;
        logic signed [SLOPE_BITS-1:0]  slope;
        logic [COLOUR_BITS-1:0]        colour;
    } t_entry;

    // Framebuffer size used for clipping.
    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
    } t_frame;

    // Scale one channel by w / WEIGHT_FULL, truncating. The reciprocal of 255
    // is formed as (p + (p >> 8) + 1) >> 8, exact over the product range.
    function automatic logic [CHAN_BITS-1:0] scale_chan(
        input logic [CHAN_BITS-1:0] c,
        input logic [FRAC_BITS-1:0] w
    );
        logic [CHAN_BITS+FRAC_BITS-1:0] p;
        logic [CHAN_BITS+FRAC_BITS:0]   s;
        p = (CHAN_BITS+FRAC_BITS)'(c) * (CHAN_BITS+FRAC_BITS)'(w);
        s = {1'b0, p} + {1'b0, (p >> FRAC_BITS)} + (CHAN_BITS+FRAC_BITS+1)'(1);
        return s[CHAN_BITS+FRAC_BITS-1:FRAC_BITS];
    endfunction

    // Weight red, green and blue; alpha passes through.
    function automatic logic [COLOUR_BITS-1:0] weigh(
        input logic [COLOUR_BITS-1:0] c,
        input logic [FRAC_BITS-1:0]   w
    );
        return {c[31:24], scale_chan(c[23:16], w), scale_chan(c[15:8], w),
                scale_chan(c[7:0], w)};
    endfunction

endpackage

// File: design/alr_front.sv
// Front end: accepts input transfers, sorts line endpoints and divides out the slope.
// Depends on alr_pkg; feeds entries into alr_queue.

module alr_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [alr_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    input  logic                                 s_axis_tuser,
    input  logic                                 i_full,
    output logic                                 o_push,
    output alr_pkg::t_entry                      o_entry
);

    localparam int CB    = alr_pkg::COORD_BITS;
    localparam int FB    = alr_pkg::FRAC_BITS;
    localparam int STEPS = FB + 1;
    localparam int CNT_BITS = $clog2(STEPS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ORDER = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_PUSH  = 2'd3;

    logic [1:0] r_state, n_state;

    // Raw endpoint registers
    logic signed [CB-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [CB:0]   r_ddx, r_ddy;
    logic [CB-1:0]        r_adx, r_ady;
    logic                 r_steep;
    logic [alr_pkg::COLOUR_BITS-1:0] r_colour;

    // Ordered line and divider registers
    logic signed [CB-1:0] r_major_pos, r_major_end, r_minor_start;
    logic                 r_axis_only;
    logic                 r_neg;
    logic [CB-1:0]        r_den, r_rem;
    logic [FB:0]          r_shf, r_quo;
    logic [CNT_BITS-1:0]  r_cnt;

    logic signed [CB-1:0] in_ax, in_ay, in_bx, in_by;
    logic signed [CB:0]   ddx, ddy, adx_w, ady_w;
    logic                 accept;

    logic signed [CB:0]   dmaj, dmin;
    logic                 swap;
    logic [CB-1:0]        amaj, amin;
    logic signed [CB-1:0] maj_a, maj_b, min_a, min_b;

    logic [CB:0]          trial;
    logic                 ge;
    logic [CB-1:0]        rem_next;
    logic signed [alr_pkg::SLOPE_BITS-1:0] quo_s, slope;

    // Input unpacking and deltas
    assign in_ax = s_axis_tdata[CB-1:0];
    assign in_ay = s_axis_tdata[2*CB-1:CB];
    assign in_bx = s_axis_tdata[3*CB-1:2*CB];
    assign in_by = s_axis_tdata[4*CB-1:3*CB];
    assign ddx   = {in_bx[CB-1], in_bx} - {in_ax[CB-1], in_ax};
    assign ddy   = {in_by[CB-1], in_by} - {in_ay[CB-1], in_ay};
    assign adx_w = ddx[CB] ? -ddx : ddx;
    assign ady_w = ddy[CB] ? -ddy : ddy;

    assign s_axis_tready = (r_state == S_IDLE) && !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Axis selection and endpoint ordering
    assign dmaj  = r_steep ? r_ddy : r_ddx;
    assign dmin  = r_steep ? r_ddx : r_ddy;
    assign amaj  = r_steep ? r_ady : r_adx;
    assign amin  = r_steep ? r_adx : r_ady;
    assign maj_a = r_steep ? r_ay : r_ax;
    assign maj_b = r_steep ? r_by : r_bx;
    assign min_a = r_steep ? r_ax : r_ay;
    assign min_b = r_steep ? r_bx : r_by;
    assign swap  = dmaj[CB];

    // One quotient bit per cycle of |minor delta| * 2^FRAC_BITS / |major delta|
    assign trial    = {r_rem, r_shf[FB]};
    assign ge       = trial >= {1'b0, r_den};
    assign rem_next = ge ? CB'(trial - {1'b0, r_den}) : trial[CB-1:0];

    assign quo_s = $signed({1'b0, r_quo});
    assign slope = (r_den == '0) ? '0 : (r_neg ? -quo_s : quo_s);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (s_axis_tuser == alr_pkg::CMD_START)) begin
                    n_state = S_ORDER;
                end
            end
            S_ORDER: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_BITS'(1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_ax     <= in_ax;
                    r_ay     <= in_ay;
                    r_bx     <= in_bx;
                    r_by     <= in_by;
                    r_ddx    <= ddx;
                    r_ddy    <= ddy;
                    r_adx    <= adx_w[CB-1:0];
                    r_ady    <= ady_w[CB-1:0];
                    r_steep  <= ady_w > adx_w;
                    r_colour <= s_axis_tdata[4*CB+alr_pkg::COLOUR_BITS-1:4*CB];
                end
            end
            S_ORDER: begin
                r_major_pos   <= swap ? maj_b : maj_a;
                r_major_end   <= swap ? maj_a : maj_b;
                r_minor_start <= swap ? min_b : min_a;
                r_axis_only   <= (amin == '0);
                r_neg         <= dmin[CB] ^ swap;
                r_den         <= amaj;
                r_rem         <= amin >> 1;
                r_shf         <= {amin[0], {FB{1'b0}}};
                r_quo         <= '0;
                r_cnt         <= CNT_BITS'(STEPS);
            end
            S_DIV: begin
                r_rem <= rem_next;
                r_quo <= {r_quo[FB-1:0], ge};
                r_shf <= {r_shf[FB-1:0], 1'b0};
                r_cnt <= r_cnt - CNT_BITS'(1);
            end
            default: begin
            end
        endcase
    end

    // Queue write: advances go straight in, prepared lines after the divide
    always_comb begin
        o_push            = 1'b0;
        o_entry.kind      = alr_pkg::CMD_ADVANCE;
        o_entry.steep     = r_steep;
        o_entry.axis_only = r_axis_only;
        o_entry.major_pos = r_major_pos;
        o_entry.major_end = r_major_end;
        o_entry.minor_start = r_minor_start;
        o_entry.slope     = slope;
        o_entry.colour    = r_colour;
        if (r_state == S_PUSH) begin
            o_push       = !i_full;
            o_entry.kind = alr_pkg::CMD_START;
        end else if (accept && (s_axis_tuser == alr_pkg::CMD_ADVANCE)) begin
            o_push = 1'b1;
        end
    end

endmodule

// File: design/alr_queue.sv
// Short first-in first-out queue of line and advance entries between front and back.
// Depends on alr_pkg for the entry type.

module alr_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  alr_pkg::t_entry  i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output alr_pkg::t_entry  o_entry,
    output logic             o_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    alr_pkg::t_entry r_slots [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_slots[r_rd_ptr];

    // Storage write
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : r_wr_ptr + PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : r_rd_ptr + PTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

endmodule

// File: design/alr_back.sv
// Back end: holds the active line, steps the DDA and drives the output register.
// Depends on alr_pkg; reads entries from alr_queue.

module alr_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  alr_pkg::t_frame                      i_frame,
    input  logic                                 i_empty,
    input  alr_pkg::t_entry                      i_entry,
    output logic                                 o_pop,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [alr_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    output logic                                 m_axis_tlast
);

    localparam int CB = alr_pkg::COORD_BITS;
    localparam int FB = alr_pkg::FRAC_BITS;
    localparam int OB = alr_pkg::OUT_BITS;
    localparam int AB = alr_pkg::ACC_BITS;
    localparam int XB = alr_pkg::COLOUR_BITS;

    // Line state
    logic                 r_active;
    logic                 r_steep, r_axis_only;
    logic signed [CB-1:0] r_major_pos, r_major_end;
    logic signed [AB-1:0] r_accum;
    logic signed [alr_pkg::SLOPE_BITS-1:0] r_slope;
    logic [XB-1:0]        r_colour;

    // Output register
    logic                 r_out_valid;
    logic [alr_pkg::OUT_DATA_BITS-1:0] r_out_data;
    logic                 r_out_last;

    logic                 is_start, can_emit, emit, last;
    logic [OB-1:0]        minor, minor_adj, major;
    logic [FB-1:0]        frac;
    logic [OB-1:0]        mx, my, nx, ny;
    logic [XB-1:0]        main_col, adj_col;
    logic                 main_in, adj_in;
    logic [alr_pkg::OUT_DATA_BITS-1:0] out_word;

    function automatic logic inside_dim(
        input logic [OB-1:0]                v,
        input logic [alr_pkg::DIM_BITS-1:0] lim
    );
        return !v[OB-1] && (v[OB-2:0] < (OB-1)'(lim));
    endfunction

    assign is_start = (i_entry.kind == alr_pkg::CMD_START);
    assign can_emit = !r_out_valid || m_axis_tready;
    assign emit     = !i_empty && !is_start && r_active && can_emit;
    assign o_pop    = !i_empty && (is_start || !r_active || can_emit);

    // Current column geometry
    assign minor     = r_accum[FB+OB-1:FB];
    assign minor_adj = minor + OB'(1);
    assign major     = {r_major_pos[CB-1], r_major_pos};
    assign frac      = r_accum[FB-1:0];
    assign last      = r_major_pos >= r_major_end;
    assign mx        = r_steep ? minor : major;
    assign my        = r_steep ? major : minor;
    assign nx        = r_steep ? minor_adj : major;
    assign ny        = r_steep ? major : minor_adj;

    assign main_in  = inside_dim(mx, i_frame.width) && inside_dim(my, i_frame.height);
    assign adj_in   = inside_dim(nx, i_frame.width) && inside_dim(ny, i_frame.height);
    assign main_col = r_axis_only ? r_colour
                                  : alr_pkg::weigh(r_colour, alr_pkg::WEIGHT_FULL - frac);
    assign adj_col  = alr_pkg::weigh(r_colour, frac);

    // Pack the result, main pixel in the lowest bits
    always_comb begin
        if (r_axis_only) begin
            out_word = {2'b00, 1'b0, {XB{1'b0}}, {OB{1'b0}}, {OB{1'b0}},
                        main_in, main_col, my, mx};
        end else begin
            out_word = {2'b00, adj_in, adj_col, ny, nx, main_in, main_col, my, mx};
        end
    end

    // Line state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_pop && is_start) begin
            r_active <= 1'b1;
        end else if (emit && last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_start) begin
            r_steep     <= i_entry.steep;
            r_axis_only <= i_entry.axis_only;
            r_major_pos <= i_entry.major_pos;
            r_major_end <= i_entry.major_end;
            r_accum     <= {{(AB-CB-FB){i_entry.minor_start[CB-1]}}, i_entry.minor_start,
                            {FB{1'b0}}};
            r_slope     <= i_entry.slope;
            r_colour    <= i_entry.colour;
        end else if (emit && !last) begin
            r_major_pos <= r_major_pos + CB'(1);
            r_accum     <= r_accum + AB'(r_slope);
        end
    end

    // Output register: refilled in the cycle its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= out_word;
            r_out_last <= last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// File: design/antialiased_line_rasterizer.sv
// Antialiased line rasterizer: start commands set up a line, advance commands emit columns.
// An advance column is registered in the queue, then in the output register; a start
// holds the input while it is ordered, has its slope divided bit-serially and is queued.
// One advance per cycle while the front end is idle and the queue has room. Synchronous
// active-low reset idles the line, empties the queue, restores the 640 by 480 frame size.
// Depends on alr_pkg, alr_front, alr_queue and alr_back.

module antialiased_line_rasterizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_addr,
    input  logic [alr_pkg::DIM_BITS-1:0]         i_cfg_wdata,
    // Command stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // start_x, start_y, end_x, end_y, line_colour
    input  logic [alr_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // cmd
    input  logic                                 s_axis_tuser,
    // Column stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // main_x, main_y, main_colour, main_valid, adj_x, adj_y, adj_colour, adj_valid, zero pad
    output logic [alr_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    // last_column
    output logic                                 m_axis_tlast
);

    alr_pkg::t_frame r_frame;
    alr_pkg::t_entry push_entry, head_entry;
    logic            push, pop, full, empty;

    // Frame size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame.width  <= alr_pkg::WIDTH_RESET;
            r_frame.height <= alr_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                alr_pkg::CFG_WIDTH:  r_frame.width  <= i_cfg_wdata;
                alr_pkg::CFG_HEIGHT: r_frame.height <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    alr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    alr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_empty (empty)
    );

    alr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (r_frame),
        .i_empty       (empty),
        .i_entry       (head_entry),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: tb/tb_antialiased_line_rasterizer.sv
// Self-checking testbench for the antialiased line rasterizer.
// Drives start and advance commands, predicts every column and checks the output stream.
// Depends on alr_pkg and antialiased_line_rasterizer.
`timescale 1ns / 100ps

module tb_antialiased_line_rasterizer;

    localparam int FULL_SCALE    = (1 << alr_pkg::FRAC_BITS) - 1;
    localparam int COORD_MIN     = -(1 << (alr_pkg::COORD_BITS - 1));
    localparam int COORD_MAX     = (1 << (alr_pkg::COORD_BITS - 1)) - 1;
    localparam int WHOLE_LINE    = -1;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_REPORTS   = 10;

    // One drawn column as seen on the output stream.
    typedef struct packed {
        logic signed [alr_pkg::OUT_BITS-1:0] main_x;
        logic signed [alr_pkg::OUT_BITS-1:0] main_y;
        logic [alr_pkg::COLOUR_BITS-1:0]     main_colour;
        logic                                main_valid;
        logic signed [alr_pkg::OUT_BITS-1:0] adj_x;
        logic signed [alr_pkg::OUT_BITS-1:0] adj_y;
        logic [alr_pkg::COLOUR_BITS-1:0]     adj_colour;
        logic                                adj_valid;
        logic                                last_column;
    } t_column;

    logic                              i_clk;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_we      = 1'b0;
    logic                              i_cfg_addr    = alr_pkg::CFG_WIDTH;
    logic [alr_pkg::DIM_BITS-1:0]      i_cfg_wdata   = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // start_x, start_y, end_x, end_y, line_colour
    logic [alr_pkg::IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
    // cmd
    logic                              s_axis_tuser  = alr_pkg::CMD_START;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // main_x, main_y, main_colour, main_valid, adj_x, adj_y, adj_colour, adj_valid, zero pad
    logic [alr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    // last_column
    logic                              m_axis_tlast;

    // Predicted line state and frame size
    logic        ln_active = 1'b0;
    logic        ln_steep  = 1'b0;
    logic        ln_flat   = 1'b0;
    int          ln_major  = 0;
    int          ln_major_end = 0;
    int          ln_accum  = 0;
    int          ln_slope  = 0;
    logic [31:0] ln_colour = '0;
    int          frame_w   = int'(alr_pkg::WIDTH_RESET);
    int          frame_h   = int'(alr_pkg::HEIGHT_RESET);

    t_column     expected_columns[$];

    // Traffic shaping and bookkeeping
    int   send_idle_pct   = 0;
    int   recv_stall_pct  = 0;
    int   hold_requests   = 0;
    int   hold_served     = 0;
    int   hold_left       = 0;
    logic hold_on         = 1'b0;
    int   items_sent      = 0;
    int   lines_started   = 0;
    int   advances_ignored = 0;
    int   columns_checked = 0;
    int   error_count     = 0;
    int   frame_settings  = 1;

    antialiased_line_rasterizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #4_000_000;
        $display("Timeout: stream stopped moving");
        $display("Simulation FAILED");
        $finish;
    end

    // Red, green and blue scaled by w / 255 with truncation; alpha is kept.
    function automatic logic [31:0] scale_rgb(input logic [31:0] c, input int w);
        logic [31:0] r;
        int          k;
        r = c & 32'hFF00_0000;
        for (k = 0; k < 3; k++) begin
            r = r | 32'((int'(c[8*k +: 8]) * w / FULL_SCALE) << (8 * k));
        end
        return r;
    endfunction

    function automatic logic pixel_inside(input int x, input int y);
        return x >= 0 && x < frame_w && y >= 0 && y < frame_h;
    endfunction

    // Latch a new line: steep test, axis swap, endpoint order and slope.
    function automatic void start_line(input logic [alr_pkg::IN_DATA_BITS-1:0] d);
        int ax, ay, bx, by, t, dx, dy;
        logic steep;
        ax = $signed(d[13:0]);
        ay = $signed(d[27:14]);
        bx = $signed(d[41:28]);
        by = $signed(d[55:42]);
        dx = (bx > ax) ? bx - ax : ax - bx;
        dy = (by > ay) ? by - ay : ay - by;
        steep = dy > dx;
        if (steep) begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
        end
        if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dx = bx - ax;
        dy = by - ay;
        ln_steep     = steep;
        ln_flat      = (dy == 0);
        ln_major     = ax;
        ln_major_end = bx;
        ln_accum     = ay * (1 << alr_pkg::FRAC_BITS);
        ln_slope     = (dx != 0) ? (dy * (1 << alr_pkg::FRAC_BITS)) / dx : 0;
        ln_colour    = d[87:56];
        ln_active    = 1'b1;
    endfunction

    // Produce the column for one advance and step the line.
    function automatic t_column advance_line();
        t_column c;
        int      minor, frac, mx, my, nx, ny;
        logic    last;
        minor = ln_accum >>> alr_pkg::FRAC_BITS;
        frac  = ln_accum & FULL_SCALE;
        last  = ln_major >= ln_major_end;
        if (ln_steep) begin
            mx = minor; my = ln_major; nx = minor + 1; ny = ln_major;
        end else begin
            mx = ln_major; my = minor; nx = ln_major; ny = minor + 1;
        end
        c.main_x      = alr_pkg::OUT_BITS'(mx);
        c.main_y      = alr_pkg::OUT_BITS'(my);
        c.main_valid  = pixel_inside(mx, my);
        c.last_column = last;
        if (ln_flat) begin
            c.main_colour = ln_colour;
            c.adj_x       = '0;
            c.adj_y       = '0;
            c.adj_colour  = '0;
            c.adj_valid   = 1'b0;
        end else begin
            c.main_colour = scale_rgb(ln_colour, FULL_SCALE - frac);
            c.adj_x       = alr_pkg::OUT_BITS'(nx);
            c.adj_y       = alr_pkg::OUT_BITS'(ny);
            c.adj_colour  = scale_rgb(ln_colour, frac);
            c.adj_valid   = pixel_inside(nx, ny);
        end
        if (last) begin
            ln_active = 1'b0;
        end else begin
            ln_major = ln_major + 1;
            ln_accum = ln_accum + ln_slope;
        end
        return c;
    endfunction

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR column %0d: %s", columns_checked, msg);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            report_error($sformatf("%s expected 0x%0h, got 0x%0h", name, exp_v, act_v));
        end
    endfunction

    // Compare one output transfer against the oldest predicted column.
    function automatic void check_column();
        t_column want;
        t_column got;
        got.main_x      = m_axis_tdata[14:0];
        got.main_y      = m_axis_tdata[29:15];
        got.main_colour = m_axis_tdata[61:30];
        got.main_valid  = m_axis_tdata[62];
        got.adj_x       = m_axis_tdata[77:63];
        got.adj_y       = m_axis_tdata[92:78];
        got.adj_colour  = m_axis_tdata[124:93];
        got.adj_valid   = m_axis_tdata[125];
        got.last_column = m_axis_tlast;
        if (expected_columns.size() == 0) begin
            report_error("column emitted with none pending");
        end else begin
            want = expected_columns.pop_front();
            compare_field("main_x", want.main_x, got.main_x);
            compare_field("main_y", want.main_y, got.main_y);
            compare_field("main_colour", want.main_colour, got.main_colour);
            compare_field("main_valid", want.main_valid, got.main_valid);
            compare_field("adj_x", want.adj_x, got.adj_x);
            compare_field("adj_y", want.adj_y, got.adj_y);
            compare_field("adj_colour", want.adj_colour, got.adj_colour);
            compare_field("adj_valid", want.adj_valid, got.adj_valid);
            compare_field("last_column", want.last_column, got.last_column);
        end
        columns_checked++;
    endfunction

    // Long receiver hold-off, counted down in cycles whenever a test asks for one.
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left--;
        end
        hold_on <= (hold_left > 0);
    end

    // Output side: check each transfer, then pick the next ready level.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_column();
            end
            if (hold_on) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic int clamp_coord(input int v);
        return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // Coordinate in and just around the frame.
    function automatic int rand_coord(input int limit);
        return clamp_coord(int'($urandom_range(limit + 16)) - 8);
    endfunction

    function automatic int rand_full_coord();
        return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
    endfunction

    function automatic logic [alr_pkg::IN_DATA_BITS-1:0] pack_line(
        input int x0, input int y0, input int x1, input int y1, input logic [31:0] colour
    );
        return {colour, y1[13:0], x1[13:0], y0[13:0], x0[13:0]};
    endfunction

    // Advances carry random payload that the block must ignore.
    function automatic logic [alr_pkg::IN_DATA_BITS-1:0] junk_payload();
        return alr_pkg::IN_DATA_BITS'({$urandom(), $urandom(), $urandom()});
    endfunction

    // Offer one command, wait for its transfer and update the prediction.
    task automatic send_cmd(input logic cmd, input logic [alr_pkg::IN_DATA_BITS-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (cmd == alr_pkg::CMD_START) begin
            start_line(data);
            lines_started++;
            items_sent++;
        end else if (ln_active) begin
            expected_columns.push_back(advance_line());
            items_sent++;
        end else begin
            advances_ignored++;
        end
    endtask

    // Start a line and advance it, over its whole length or only partway.
    task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                             input logic [31:0] colour, input int max_cols);
        int cols;
        send_cmd(alr_pkg::CMD_START, pack_line(x0, y0, x1, y1, colour));
        cols = ln_major_end - ln_major + 1;
        if (max_cols >= 0 && max_cols < cols) cols = max_cols;
        repeat (cols) send_cmd(alr_pkg::CMD_ADVANCE, junk_payload());
    endtask

    // Let every pending column arrive and any start finish its setup.
    task automatic wait_idle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_columns.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both frame registers; only called with the block idle.
    task automatic set_frame(input int width, input int height);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= alr_pkg::CFG_WIDTH;
        i_cfg_wdata <= alr_pkg::DIM_BITS'(width);
        @(posedge i_clk);
        i_cfg_addr  <= alr_pkg::CFG_HEIGHT;
        i_cfg_wdata <= alr_pkg::DIM_BITS'(height);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_w = width & 'h1FFF;
        frame_h = height & 'h1FFF;
        frame_settings++;
        @(posedge i_clk);
    endtask

    // Hand-picked lines: flat, single point, reversed vertical, exact diagonal,
    // steep with falling slope, coordinate extremes and stray advances.
    task automatic test_directed();
        send_cmd(alr_pkg::CMD_ADVANCE, junk_payload());
        draw_line(10, 5, 13, 5, 32'h80FF_8040, WHOLE_LINE);
        send_cmd(alr_pkg::CMD_ADVANCE, junk_payload());
        draw_line(7, 7, 7, 7, 32'hFFFF_FFFF, WHOLE_LINE);
        draw_line(3, 7, 3, 5, 32'h1234_5678, WHOLE_LINE);
        draw_line(0, 0, 2, 2, 32'hFFFF_FFFF, WHOLE_LINE);
        draw_line(4, 0, 3, 3, 32'hA0C0_E0FF, WHOLE_LINE);
        draw_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'h0000_0000, 1);
        draw_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 32'hFFFF_FFFF, 2);
        wait_idle();
    endtask

    // Mostly short complete lines around the frame, some huge lines cut short,
    // some abandoned by a new start, and a few stray advances.
    task automatic test_random(input int n_items);
        int target, pick, x0, y0;
        target = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            x0 = rand_coord(frame_w);
            y0 = rand_coord(frame_h);
            if (pick < 80) begin
                draw_line(x0, y0, clamp_coord(x0 + int'($urandom_range(48)) - 24),
                          clamp_coord(y0 + int'($urandom_range(48)) - 24),
                          $urandom(), WHOLE_LINE);
            end else if (pick < 92) begin
                draw_line(rand_full_coord(), rand_full_coord(), rand_full_coord(),
                          rand_full_coord(), $urandom(), $urandom_range(6));
            end else if (pick < 96) begin
                draw_line(x0, y0, rand_coord(frame_w), rand_coord(frame_h), $urandom(),
                          $urandom_range(3));
            end else begin
                send_cmd(alr_pkg::CMD_ADVANCE, junk_payload());
            end
        end
        wait_idle();
    endtask

    // Output held off for a long stretch while a long line keeps coming, so the
    // internal queue fills and the input stalls.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        draw_line(0, 10, 149, 70, 32'hC0FF_2080, WHOLE_LINE);
        wait_idle();
    endtask

    // Test sequence.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300);

        set_frame(1, 4096);
        send_idle_pct = 71;
        test_random(300);

        set_frame(4096, 1);
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        test_random(300);

        set_frame(0, 8191);
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        test_random(200);

        set_frame(200, 150);
        test_backpressure();

        send_idle_pct  = 35;
        recv_stall_pct = 35;
        test_random(100);

        if (expected_columns.size() != 0) begin
            error_count += expected_columns.size();
            $display("ERROR: %0d columns never arrived", expected_columns.size());
        end
        $display("Covered %0d lines and %0d checked columns over %0d frame sizes,",
                 lines_started, columns_checked, frame_settings);
        $display("with %0d stray advances, idle and stall mixes and one long hold-off.",
                 advances_ignored);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
